// File: hdl/i3ctb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i3ctb_pkg
// Shared types, codes and sizes for the I3C target byte buffer.
// ----------------------------------------------------------------------------
package i3ctb_pkg;

	localparam int STORE_DEPTH = 256;
	localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int PTR_W       = $clog2(STORE_DEPTH + 1);
	localparam int SIZE_W      = (PTR_W > 9) ? PTR_W : 9;

	localparam logic [8:0]  BUFFER_SIZE_RST = 9'd256;
	localparam logic [7:0]  TRIGGER_RST     = 8'd0;
	localparam logic [23:0] DELAY_RST       = 24'd1000000;

	// item kinds
	typedef enum logic [2:0] {
		FN_PWRITE = 3'd0,
		FN_PREAD  = 3'd1,
		FN_CWRITE = 3'd2,
		FN_CREAD  = 3'd3,
		FN_STOP   = 3'd4,
		FN_TICK   = 3'd5
	} func_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_DROP    = 2'd1,
		ST_CCC_ERR = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CFG_BUFFER_SIZE = 2'd0,
		CFG_TRIGGER     = 2'd1,
		CFG_DELAY       = 2'd2
	} cfg_idx_t;

	// CCC codes (broadcast _B, direct _D)
	localparam logic [7:0] CC_ENEC_B    = 8'h00;
	localparam logic [7:0] CC_DISEC_B   = 8'h01;
	localparam logic [7:0] CC_RSTDAA_B  = 8'h06;
	localparam logic [7:0] CC_ENTDAA_B  = 8'h07;
	localparam logic [7:0] CC_SETAASA_B = 8'h29;
	localparam logic [7:0] CC_ENEC_D    = 8'h80;
	localparam logic [7:0] CC_DISEC_D   = 8'h81;
	localparam logic [7:0] CC_SETDASA_D = 8'h87;
	localparam logic [7:0] CC_GETMWL_D  = 8'h8b;
	localparam logic [7:0] CC_GETMRL_D  = 8'h8c;
	localparam logic [7:0] CC_GETPID_D  = 8'h8d;
	localparam logic [7:0] CC_GETBCR_D  = 8'h8e;
	localparam logic [7:0] CC_GETDCR_D  = 8'h8f;
	localparam logic [7:0] CC_GETMXDS_D = 8'h94;
	localparam logic [7:0] CC_GETCAPS_D = 8'h95;

	localparam logic [7:0] CAPS_BYTE1 = 8'h01;

	// request into the byte store
	typedef struct packed {
		logic              we;
		logic              re;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        wdata;
	} store_req_t;

endpackage

// File: hdl/i3ctb_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i3ctb_store
// Byte store: one port, registered read, per-entry valid bits so that
// entries never written read as zero after reset.
// ----------------------------------------------------------------------------
module i3ctb_store (
	input  logic                   clk,
	input  logic                   arst_n,
	input  i3ctb_pkg::store_req_t  req,
	output logic [7:0]             rdata
);

	logic [7:0]                      mem [i3ctb_pkg::STORE_DEPTH];
	logic [i3ctb_pkg::STORE_DEPTH-1:0] valid_q;
	logic [7:0]                      rd_q;
	logic                            rd_valid_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.re) begin
			rd_q <= mem[req.addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (req.we) begin
				valid_q[req.addr] <= 1'b1;
			end
			if (req.re) begin
				rd_valid_q <= valid_q[req.addr];
			end
		end
	end

	assign rdata = rd_valid_q ? rd_q : 8'd0;

endmodule

// File: hdl/i3c_target_buffer_with_ccc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i3c_target_buffer_with_ccc
// I3C target modeled as a small EEPROM-like byte buffer, one bus byte per
// transfer, with a handful of CCCs and a tick-driven IBI countdown.
// ----------------------------------------------------------------------------
// Each input transfer is one bus event (private write/read byte, CCC
// write/read byte, STOP or timer tick) and yields exactly one result
// transfer. The block takes one transfer per clock while the result stream
// does not stall it; the taking edge loads stage 1 and launches the
// registered read of the byte store, and stage 1 moves on into the output
// register when the output slot is free or taken. The store is a
// single-port synchronous memory that is touched at most once per
// transfer, which is what sets the one-per-clock figure; valid bits make it
// read as zero after reset without a clearing pass. Pointer, CCC state and
// countdown are updated when a transfer is taken, so back-to-back items see
// each other's effect with no stall. Configuration registers are written
// through the cfg port, which is always ready; write them only while idle.
// ----------------------------------------------------------------------------
module i3c_target_buffer_with_ccc (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] wdata
	input  logic [3:0]  s_tuser,   // [2:0] func, [3] lone_byte
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] rdata
	output logic [3:0]  m_tuser,   // [0] rvalid, [2:1] status, [3] ibi_request
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	localparam int SIZE_W = i3ctb_pkg::SIZE_W;
	localparam int PTR_W  = i3ctb_pkg::PTR_W;

	// config registers
	logic [8:0]  buffer_size_q;
	logic [7:0]  trigger_q;
	logic [23:0] delay_q;

	// protocol state
	logic [PTR_W-1:0] ptr_q;
	logic [7:0]       ccc_code_q;
	logic [1:0]       ccc_off_q;
	logic             events_q;
	logic             armed_q;
	logic [23:0]      count_q;

	// stage 1 (store read in flight) and output register
	logic        v_s1;
	logic        from_store_s1;
	logic [7:0]  rdata_s1;
	logic        rvalid_s1;
	logic [1:0]  status_s1;
	logic        ibi_s1;

	logic [7:0]  out_rdata_q;
	logic        out_rvalid_q;
	logic [1:0]  out_status_q;
	logic        out_ibi_q;
	logic        out_v_q;

	logic        adv_s1;
	logic        acc;
	logic        cfg_acc;

	i3ctb_pkg::func_t    fn;
	i3ctb_pkg::store_req_t req;
	logic [7:0]          store_rdata;

	logic [SIZE_W-1:0] size;
	logic [15:0]       size16;
	logic              ptr_in;
	logic [7:0]        code_eff;

	// next-state and result of the item being taken
	logic [PTR_W-1:0]  ptr_d;
	logic [7:0]        ccc_code_d;
	logic [1:0]        ccc_off_d;
	logic              events_d;
	logic              armed_d;
	logic [23:0]       count_d;
	logic              from_store_d;
	logic [7:0]        rdata_d;
	logic              rvalid_d;
	i3ctb_pkg::status_t status_d;
	logic              ibi_d;

	// two-register pipeline; s1 moves on when the output slot is free or taken
	assign adv_s1    = !out_v_q || m_tready;
	assign s_tready  = !v_s1 || adv_s1;
	assign acc       = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid && cfg_ready;

	assign fn     = i3ctb_pkg::func_t'(s_tuser[2:0]);
	assign size   = (buffer_size_q < SIZE_W'(i3ctb_pkg::STORE_DEPTH))
		? SIZE_W'(buffer_size_q) : SIZE_W'(i3ctb_pkg::STORE_DEPTH);
	assign size16 = 16'(size);
	assign ptr_in = SIZE_W'(ptr_q) < size;
	// first CCC byte after STOP latches the code
	assign code_eff = (ccc_code_q == i3ctb_pkg::CC_ENEC_B) ? s_tdata : ccc_code_q;

	always_comb begin
		ptr_d        = ptr_q;
		ccc_code_d   = ccc_code_q;
		ccc_off_d    = ccc_off_q;
		events_d     = events_q;
		armed_d      = armed_q;
		count_d      = count_q;
		from_store_d = 1'b0;
		rdata_d      = 8'd0;
		rvalid_d     = 1'b0;
		status_d     = i3ctb_pkg::ST_OK;
		ibi_d        = 1'b0;
		req.we       = 1'b0;
		req.re       = 1'b0;
		req.addr     = ptr_q[i3ctb_pkg::ADDR_W-1:0];
		req.wdata    = s_tdata;

		unique case (fn)
			i3ctb_pkg::FN_PWRITE: begin
				if (trigger_q != 8'd0 && s_tuser[3] && s_tdata == trigger_q) begin
					armed_d = 1'b1;
					count_d = delay_q;
				end else if (!ptr_in) begin
					status_d = i3ctb_pkg::ST_DROP;
				end else begin
					req.we = acc;
					ptr_d  = PTR_W'(ptr_q + 1'b1);
				end
			end
			i3ctb_pkg::FN_PREAD: begin
				if (ptr_in) begin
					req.re       = acc;
					from_store_d = 1'b1;
					rvalid_d     = 1'b1;
					ptr_d        = PTR_W'(ptr_q + 1'b1);
				end
			end
			i3ctb_pkg::FN_CWRITE: begin
				ccc_code_d = code_eff;
				case (code_eff) inside
					i3ctb_pkg::CC_ENEC_B, i3ctb_pkg::CC_ENEC_D: events_d = 1'b1;
					i3ctb_pkg::CC_DISEC_B, i3ctb_pkg::CC_DISEC_D: events_d = 1'b0;
					i3ctb_pkg::CC_ENTDAA_B, i3ctb_pkg::CC_SETAASA_B,
					i3ctb_pkg::CC_RSTDAA_B, i3ctb_pkg::CC_SETDASA_D,
					i3ctb_pkg::CC_GETPID_D, i3ctb_pkg::CC_GETBCR_D,
					i3ctb_pkg::CC_GETDCR_D, i3ctb_pkg::CC_GETMWL_D,
					i3ctb_pkg::CC_GETMRL_D, i3ctb_pkg::CC_GETMXDS_D,
					i3ctb_pkg::CC_GETCAPS_D: ;
					default: status_d = i3ctb_pkg::ST_CCC_ERR;
				endcase
			end
			i3ctb_pkg::FN_CREAD: begin
				case (ccc_code_q) inside
					i3ctb_pkg::CC_GETMXDS_D, i3ctb_pkg::CC_GETCAPS_D,
					i3ctb_pkg::CC_GETMWL_D, i3ctb_pkg::CC_GETMRL_D: begin
						// two bytes, then nothing
						if (!ccc_off_q[1]) begin
							rvalid_d  = 1'b1;
							ccc_off_d = ccc_off_q + 2'd1;
							if (ccc_code_q == i3ctb_pkg::CC_GETCAPS_D) begin
								rdata_d = ccc_off_q[0] ? i3ctb_pkg::CAPS_BYTE1 : 8'd0;
							end else if (ccc_code_q == i3ctb_pkg::CC_GETMXDS_D) begin
								rdata_d = 8'd0;
							end else begin
								rdata_d = ccc_off_q[0] ? size16[7:0] : size16[15:8];
							end
						end
					end
					i3ctb_pkg::CC_ENTDAA_B, i3ctb_pkg::CC_GETPID_D,
					i3ctb_pkg::CC_GETBCR_D, i3ctb_pkg::CC_GETDCR_D: ;
					default: status_d = i3ctb_pkg::ST_CCC_ERR;
				endcase
			end
			i3ctb_pkg::FN_STOP: begin
				ccc_code_d = i3ctb_pkg::CC_ENEC_B;
				ccc_off_d  = 2'd0;
				ptr_d      = '0;
			end
			i3ctb_pkg::FN_TICK: begin
				if (armed_q) begin
					// zero delay behaves as one tick
					if (count_q <= 24'd1) begin
						count_d = 24'd0;
						armed_d = 1'b0;
						ibi_d   = events_q;
					end else begin
						count_d = count_q - 24'd1;
					end
				end
			end
			default: ;
		endcase
	end

	i3ctb_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rdata  (store_rdata)
	);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_size_q <= i3ctb_pkg::BUFFER_SIZE_RST;
			trigger_q     <= i3ctb_pkg::TRIGGER_RST;
			delay_q       <= i3ctb_pkg::DELAY_RST;
		end else if (cfg_acc) begin
			unique case (i3ctb_pkg::cfg_idx_t'(cfg_index))
				i3ctb_pkg::CFG_BUFFER_SIZE: buffer_size_q <= cfg_data[8:0];
				i3ctb_pkg::CFG_TRIGGER:     trigger_q     <= cfg_data[7:0];
				i3ctb_pkg::CFG_DELAY:       delay_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	// protocol state, committed when the item is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q      <= '0;
			ccc_code_q <= i3ctb_pkg::CC_ENEC_B;
			ccc_off_q  <= 2'd0;
			events_q   <= 1'b0;
			armed_q    <= 1'b0;
			count_q    <= 24'd0;
		end else if (acc) begin
			ptr_q      <= ptr_d;
			ccc_code_q <= ccc_code_d;
			ccc_off_q  <= ccc_off_d;
			events_q   <= events_d;
			armed_q    <= armed_d;
			count_q    <= count_d;
		end
	end

	// stage 1 and output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (s_tready) begin
				v_s1 <= s_tvalid;
			end
			if (adv_s1) begin
				out_v_q <= v_s1;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (acc) begin
			from_store_s1 <= from_store_d;
			rdata_s1      <= rdata_d;
			rvalid_s1     <= rvalid_d;
			status_s1     <= status_d;
			ibi_s1        <= ibi_d;
		end
		if (adv_s1 && v_s1) begin
			out_rdata_q  <= from_store_s1 ? store_rdata : rdata_s1;
			out_rvalid_q <= rvalid_s1;
			out_status_q <= status_s1;
			out_ibi_q    <= ibi_s1;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_rdata_q;
	assign m_tuser  = {out_ibi_q, out_status_q, out_rvalid_q};

endmodule

// File: hdl/i3ctb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i3ctb_checker
// Port-level checks on the result stream of the I3C target buffer.
// ----------------------------------------------------------------------------
module i3ctb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic [3:0] m_tuser
);

	// no read byte means a zero data byte
	a_rdata_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == 8'd0)
		else $error("rdata nonzero without rvalid");

	// a supplied read byte always reports ok status and no interrupt
	a_read_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tuser[2:1] == i3ctb_pkg::ST_OK && !m_tuser[3])
		else $error("read byte with error or ibi");

	// interrupt only comes from a tick, which carries no error
	a_ibi_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[3] |-> m_tuser[2:1] == i3ctb_pkg::ST_OK)
		else $error("ibi with error status");

	// stalled result stays up
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result dropped under stall");

endmodule

bind i3c_target_buffer_with_ccc i3ctb_checker u_i3ctb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// File: tb/sv/i3c_target_buffer_with_ccc_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i3c_target_buffer_with_ccc_tb
// Self-checking testbench for the I3C target byte buffer with CCC support.
// ----------------------------------------------------------------------------
// A behavioral copy of the target (byte store, pointer, CCC latch, event
// enable, IBI countdown) predicts the one reply of each bus item. Directed
// checks cover power-on contents, private access, CCC replies, store bounds
// and the IBI countdown. Then random bus traffic runs under several
// register settings and idle/stall mixes. Each reply is compared field by
// field against the oldest prediction.
// ----------------------------------------------------------------------------
module i3c_target_buffer_with_ccc_tb;

	localparam int CLK_HALF      = 2;
	localparam int RESET_CYCLES  = 7;
	localparam int SETTLE_CYCLES = 8;       // pipeline drain plus margin
	localparam int CYCLE_LIMIT   = 200000;  // guard against a hung run
	localparam int SEGMENT_ITEMS = 135;
	localparam int MAX_PRINTED   = 50;

	// func codes the block ignores
	localparam logic [2:0] FN_UNUSED6 = 3'd6;
	localparam logic [2:0] FN_UNUSED7 = 3'd7;

	// empty CCC latch, and a code the target does not know
	localparam logic [7:0] NO_CCC        = 8'h00;
	localparam logic [7:0] CC_UNASSIGNED = 8'h55;

	// one reply as the target should give it
	typedef struct packed {
		logic [7:0]         rdata;
		logic               rvalid;
		i3ctb_pkg::status_t status;
		logic               ibi;
	} target_reply_t;

	// ------------------------------------------------------------------
	// DUT hookup; every input holds a known value from time zero
	// ------------------------------------------------------------------
	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = 8'h00;   // [7:0] wdata
	logic [3:0]  s_tuser   = 4'h0;    // [2:0] func, [3] lone_byte
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [7:0]  m_tdata;             // [7:0] rdata
	logic [3:0]  m_tuser;             // [0] rvalid, [2:1] status, [3] ibi_request
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = 2'd0;
	logic [23:0] cfg_data  = 24'd0;

	i3c_target_buffer_with_ccc dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(CLK_HALF) clk = ~clk;

	// ------------------------------------------------------------------
	// Predicted target state: registers, store image and bus state
	// ------------------------------------------------------------------
	logic [8:0]  cfg_buffer_size = i3ctb_pkg::BUFFER_SIZE_RST;
	logic [7:0]  cfg_trigger     = i3ctb_pkg::TRIGGER_RST;
	logic [23:0] cfg_delay       = i3ctb_pkg::DELAY_RST;

	logic [7:0]  store_image [i3ctb_pkg::STORE_DEPTH] = '{default: 8'h00};
	logic [8:0]  ptr          = 9'd0;
	logic [7:0]  ccc_latch    = NO_CCC;
	logic [1:0]  ccc_offset   = 2'd0;
	logic        events_on    = 1'b0;
	logic        ibi_armed    = 1'b0;
	logic [23:0] ibi_count    = 24'd0;

	target_reply_t expected_replies [$];
	target_reply_t head_reply;

	// idle mix of the running phase, in percent of cycles
	int unsigned sender_idle_pct    = 0;
	int unsigned receiver_stall_pct = 0;

	// bookkeeping for the summary
	int unsigned error_count    = 0;
	int unsigned items_sent     = 0;
	int unsigned replies_seen   = 0;
	int unsigned reads_supplied = 0;
	int unsigned writes_dropped = 0;
	int unsigned ccc_errors     = 0;
	int unsigned ibi_raised     = 0;
	int unsigned settings_used  = 1;
	int unsigned cycle_count    = 0;

	task automatic report_error(input string msg);
		error_count++;
		if (error_count <= MAX_PRINTED)
			$display("[%0t] ERROR: %s", $time, msg);
	endtask

	// Next reply of the target for one bus item; updates the predicted state.
	function automatic target_reply_t target_step(input logic [2:0] f,
			input logic [7:0] wd, input logic lone);
		target_reply_t r;
		logic [8:0]    span;
		r = '{rdata: 8'h00, rvalid: 1'b0, status: i3ctb_pkg::ST_OK, ibi: 1'b0};
		// size beyond the store clamps to the store depth
		span = (cfg_buffer_size > i3ctb_pkg::STORE_DEPTH)
			? 9'(i3ctb_pkg::STORE_DEPTH) : cfg_buffer_size;
		case (f)
			i3ctb_pkg::FN_PWRITE: begin
				// a lone trigger byte arms the countdown and is not stored
				if (cfg_trigger != 8'h00 && lone && wd == cfg_trigger) begin
					ibi_armed = 1'b1;
					ibi_count = cfg_delay;
				end else if (ptr >= span) begin
					r.status = i3ctb_pkg::ST_DROP;
				end else begin
					store_image[ptr[i3ctb_pkg::ADDR_W-1:0]] = wd;
					ptr++;
				end
			end
			i3ctb_pkg::FN_PREAD: begin
				if (ptr < span) begin
					r.rdata  = store_image[ptr[i3ctb_pkg::ADDR_W-1:0]];
					r.rvalid = 1'b1;
					ptr++;
				end
			end
			i3ctb_pkg::FN_CWRITE: begin
				// broadcast ENEC (zero) leaves the latch empty
				if (ccc_latch == NO_CCC)
					ccc_latch = wd;
				case (ccc_latch)
					i3ctb_pkg::CC_ENEC_B, i3ctb_pkg::CC_ENEC_D:   events_on = 1'b1;
					i3ctb_pkg::CC_DISEC_B, i3ctb_pkg::CC_DISEC_D: events_on = 1'b0;
					i3ctb_pkg::CC_ENTDAA_B, i3ctb_pkg::CC_SETAASA_B,
					i3ctb_pkg::CC_RSTDAA_B, i3ctb_pkg::CC_SETDASA_D,
					i3ctb_pkg::CC_GETPID_D, i3ctb_pkg::CC_GETBCR_D,
					i3ctb_pkg::CC_GETDCR_D, i3ctb_pkg::CC_GETMWL_D,
					i3ctb_pkg::CC_GETMRL_D, i3ctb_pkg::CC_GETMXDS_D,
					i3ctb_pkg::CC_GETCAPS_D: ;
					default: r.status = i3ctb_pkg::ST_CCC_ERR;
				endcase
			end
			i3ctb_pkg::FN_CREAD: begin
				case (ccc_latch)
					i3ctb_pkg::CC_GETMXDS_D, i3ctb_pkg::CC_GETCAPS_D,
					i3ctb_pkg::CC_GETMWL_D, i3ctb_pkg::CC_GETMRL_D: begin
						if (ccc_offset < 2'd2) begin
							if (ccc_latch == i3ctb_pkg::CC_GETCAPS_D)
								r.rdata = (ccc_offset == 2'd1) ? i3ctb_pkg::CAPS_BYTE1 : 8'h00;
							else if (ccc_latch == i3ctb_pkg::CC_GETMXDS_D)
								r.rdata = 8'h00;
							else
								r.rdata = (ccc_offset == 2'd0) ? {7'd0, span[8]} : span[7:0];
							r.rvalid = 1'b1;
							ccc_offset++;
						end
					end
					i3ctb_pkg::CC_ENTDAA_B, i3ctb_pkg::CC_GETPID_D,
					i3ctb_pkg::CC_GETBCR_D, i3ctb_pkg::CC_GETDCR_D: ;
					default: r.status = i3ctb_pkg::ST_CCC_ERR;
				endcase
			end
			i3ctb_pkg::FN_STOP: begin
				ccc_latch  = NO_CCC;
				ccc_offset = 2'd0;
				ptr        = 9'd0;
			end
			i3ctb_pkg::FN_TICK: begin
				// delay zero expires on the first tick, like delay one
				if (ibi_armed) begin
					if (ibi_count <= 24'd1) begin
						ibi_count = 24'd0;
						ibi_armed = 1'b0;
						r.ibi     = events_on;
					end else begin
						ibi_count--;
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Send one bus item; tvalid stays high afterwards unless a gap or a
	// settle lowers it, so back-to-back items never toggle it in one step.
	// ------------------------------------------------------------------
	task automatic send_item(input logic [2:0] f, input logic [7:0] wd, input logic lone);
		target_reply_t r;
		if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= wd;
		s_tuser  <= {lone, f};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		// transfer taken at this edge
		r = target_step(f, wd, lone);
		expected_replies.push_back(r);
		items_sent++;
		if (r.rvalid) reads_supplied++;
		if (r.status == i3ctb_pkg::ST_DROP) writes_dropped++;
		if (r.status == i3ctb_pkg::ST_CCC_ERR) ccc_errors++;
		if (r.ibi) ibi_raised++;
	endtask

	// Stop sending, wait for every predicted reply, then let the pipe empty.
	task automatic settle_idle;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_replies.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input i3ctb_pkg::cfg_idx_t idx, input logic [23:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// All three registers in a row; only called while the block is idle.
	task automatic apply_settings(input logic [8:0] size, input logic [7:0] trig,
			input logic [23:0] delay);
		write_register(i3ctb_pkg::CFG_BUFFER_SIZE, {15'd0, size});
		write_register(i3ctb_pkg::CFG_TRIGGER, {16'd0, trig});
		write_register(i3ctb_pkg::CFG_DELAY, delay);
		cfg_valid       <= 1'b0;
		cfg_buffer_size  = size;
		cfg_trigger      = trig;
		cfg_delay        = delay;
		settings_used++;
	endtask

	// ------------------------------------------------------------------
	// Reply checker and receiver stalls
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			replies_seen++;
			if (expected_replies.size() == 0) begin
				report_error($sformatf("reply with nothing pending: tdata %02h tuser %h",
					m_tdata, m_tuser));
			end else begin
				head_reply = expected_replies.pop_front();
				if (m_tdata !== head_reply.rdata)
					report_error($sformatf("reply %0d rdata %02h, expected %02h",
						replies_seen, m_tdata, head_reply.rdata));
				if (m_tuser[0] !== head_reply.rvalid)
					report_error($sformatf("reply %0d rvalid %b, expected %b",
						replies_seen, m_tuser[0], head_reply.rvalid));
				if (m_tuser[2:1] !== head_reply.status)
					report_error($sformatf("reply %0d status %0d, expected %0d",
						replies_seen, m_tuser[2:1], head_reply.status));
				if (m_tuser[3] !== head_reply.ibi)
					report_error($sformatf("reply %0d ibi_request %b, expected %b",
						replies_seen, m_tuser[3], head_reply.ibi));
			end
		end
		m_tready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	// run guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d replies pending",
				cycle_count, expected_replies.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Directed tests
	// ------------------------------------------------------------------

	// store reads zero after reset; CCC read with no code; ignored funcs
	task automatic test_power_on;
		send_item(i3ctb_pkg::FN_PREAD, 8'h00, 1'b0);
		send_item(i3ctb_pkg::FN_CREAD, 8'hff, 1'b1);
		send_item(FN_UNUSED6, 8'h5a, 1'b0);
		send_item(FN_UNUSED7, 8'hff, 1'b1);
		send_item(i3ctb_pkg::FN_STOP, 8'h00, 1'b0);
	endtask

	// extreme bytes written and read back; lone byte stored while trigger is off
	task automatic test_private_access;
		send_item(i3ctb_pkg::FN_PWRITE, 8'hff, 1'b0);
		send_item(i3ctb_pkg::FN_PWRITE, 8'h00, 1'b1);
		send_item(i3ctb_pkg::FN_STOP, 8'h00, 1'b0);
		send_item(i3ctb_pkg::FN_PREAD, 8'h00, 1'b0);
		send_item(i3ctb_pkg::FN_PREAD, 8'h00, 1'b0);
	endtask

	// broadcast ENEC keeps the latch empty, GETMWL gives two bytes, unknown code
	task automatic test_ccc_replies;
		send_item(i3ctb_pkg::FN_CWRITE, i3ctb_pkg::CC_ENEC_B, 1'b0);
		send_item(i3ctb_pkg::FN_CWRITE, i3ctb_pkg::CC_GETMWL_D, 1'b0);
		send_item(i3ctb_pkg::FN_CREAD, 8'h00, 1'b0);
		send_item(i3ctb_pkg::FN_CREAD, 8'h00, 1'b0);
		send_item(i3ctb_pkg::FN_CREAD, 8'h00, 1'b0);
		send_item(i3ctb_pkg::FN_STOP, 8'h00, 1'b0);
		send_item(i3ctb_pkg::FN_CWRITE, CC_UNASSIGNED, 1'b0);
		send_item(i3ctb_pkg::FN_CREAD, 8'h00, 1'b0);
		send_item(i3ctb_pkg::FN_STOP, 8'h00, 1'b0);
	endtask

	// one-byte store, trigger 0xff with zero delay, then oversized store
	task automatic test_store_bounds;
		settle_idle();
		apply_settings(9'd1, 8'hff, 24'd0);
		send_item(i3ctb_pkg::FN_PWRITE, 8'hff, 1'b1);   // arms, not stored
		send_item(i3ctb_pkg::FN_TICK, 8'h00, 1'b0);     // expires at once, events on
		send_item(i3ctb_pkg::FN_PWRITE, 8'h11, 1'b0);
		send_item(i3ctb_pkg::FN_PWRITE, 8'h22, 1'b0);   // past the end
		send_item(i3ctb_pkg::FN_STOP, 8'h00, 1'b0);
		send_item(i3ctb_pkg::FN_PREAD, 8'h00, 1'b0);
		send_item(i3ctb_pkg::FN_PREAD, 8'h00, 1'b0);    // nothing left
		send_item(i3ctb_pkg::FN_STOP, 8'h00, 1'b0);
		settle_idle();
		apply_settings(9'd511, 8'h00, 24'hffffff);
		send_item(i3ctb_pkg::FN_CWRITE, i3ctb_pkg::CC_GETMRL_D, 1'b0);
		send_item(i3ctb_pkg::FN_CREAD, 8'h00, 1'b0);    // clamped size, MSB first
		send_item(i3ctb_pkg::FN_CREAD, 8'h00, 1'b0);
		send_item(i3ctb_pkg::FN_STOP, 8'h00, 1'b0);
	endtask

	// ------------------------------------------------------------------
	// Random bus traffic
	// ------------------------------------------------------------------
	function automatic logic [7:0] pick_ccc_code;
		case ($urandom_range(17))
			0:  return i3ctb_pkg::CC_ENEC_B;
			1:  return i3ctb_pkg::CC_DISEC_B;
			2:  return i3ctb_pkg::CC_RSTDAA_B;
			3:  return i3ctb_pkg::CC_ENTDAA_B;
			4:  return i3ctb_pkg::CC_SETAASA_B;
			5:  return i3ctb_pkg::CC_ENEC_D;
			6:  return i3ctb_pkg::CC_DISEC_D;
			7:  return i3ctb_pkg::CC_SETDASA_D;
			8:  return i3ctb_pkg::CC_GETMWL_D;
			9:  return i3ctb_pkg::CC_GETMRL_D;
			10: return i3ctb_pkg::CC_GETPID_D;
			11: return i3ctb_pkg::CC_GETBCR_D;
			12: return i3ctb_pkg::CC_GETDCR_D;
			13: return i3ctb_pkg::CC_GETMXDS_D;
			14: return i3ctb_pkg::CC_GETCAPS_D;
			15: return i3ctb_pkg::CC_ENEC_D;
			default: return 8'($urandom);
		endcase
	endfunction

	// favors the trigger value so the countdown gets armed often
	function automatic logic [7:0] pick_write_byte;
		if (cfg_trigger != 8'h00 && $urandom_range(3) == 0)
			return cfg_trigger;
		return 8'($urandom);
	endfunction

	// mostly well-formed transfers with random content, some noise
	task automatic run_random_traffic(input int unsigned n_items);
		int unsigned first;
		int unsigned kind;
		int unsigned len;
		int unsigned k;
		first = items_sent;
		while (items_sent - first < n_items) begin
			kind = $urandom_range(99);
			if (kind < 28) begin
				// private write, possibly a lone byte
				len = $urandom_range(1, 6);
				if (len == 1 && $urandom_range(1))
					send_item(i3ctb_pkg::FN_PWRITE, pick_write_byte(), 1'b1);
				else
					for (k = 0; k < len; k++)
						send_item(i3ctb_pkg::FN_PWRITE, pick_write_byte(), 1'b0);
				if ($urandom_range(3) != 0)
					send_item(i3ctb_pkg::FN_STOP, 8'($urandom), 1'($urandom));
			end else if (kind < 46) begin
				len = $urandom_range(1, 8);
				for (k = 0; k < len; k++)
					send_item(i3ctb_pkg::FN_PREAD, 8'($urandom), 1'($urandom));
				if ($urandom_range(3) != 0)
					send_item(i3ctb_pkg::FN_STOP, 8'($urandom), 1'($urandom));
			end else if (kind < 72) begin
				// CCC: code byte, maybe more write bytes, then reads
				send_item(i3ctb_pkg::FN_CWRITE, pick_ccc_code(), 1'($urandom));
				len = $urandom_range(0, 2);
				for (k = 0; k < len; k++)
					send_item(i3ctb_pkg::FN_CWRITE, 8'($urandom), 1'($urandom));
				len = $urandom_range(0, 3);
				for (k = 0; k < len; k++)
					send_item(i3ctb_pkg::FN_CREAD, 8'($urandom), 1'($urandom));
				if ($urandom_range(7) != 0)
					send_item(i3ctb_pkg::FN_STOP, 8'($urandom), 1'($urandom));
			end else if (kind < 90) begin
				len = $urandom_range(1, 8);
				for (k = 0; k < len; k++)
					send_item(i3ctb_pkg::FN_TICK, 8'($urandom), 1'($urandom));
			end else begin
				// noise, unused func codes included
				send_item(3'($urandom_range(FN_UNUSED7)), 8'($urandom), 1'($urandom));
			end
		end
	endtask

	// eight segments: two settings per idle mix; the pointer carries over
	// between segments, so a lowered size finds it past the end
	task automatic test_random_traffic;
		logic [8:0]  sizes  [8] = '{9'd256, 9'd1, 9'd511, 9'd16, 9'd0, 9'd2, 9'd200, 9'd5};
		logic [7:0]  trigs  [8] = '{8'h5a, 8'hff, 8'h01, 8'h00, 8'h80, 8'h33, 8'hff, 8'h7e};
		logic [23:0] delays [8] = '{24'd1, 24'd0, 24'd3, 24'hffffff, 24'd5, 24'd2, 24'd1, 24'd4};
		int unsigned seg;
		for (seg = 0; seg < 8; seg++) begin
			settle_idle();
			case (seg / 2)
				0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
				1: begin sender_idle_pct = 75; receiver_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  receiver_stall_pct = 75; end
				default: begin sender_idle_pct = 35; receiver_stall_pct = 35; end
			endcase
			apply_settings(sizes[seg], trigs[seg], delays[seg]);
			run_random_traffic(SEGMENT_ITEMS);
		end
		settle_idle();
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_power_on();
		test_private_access();
		test_ccc_replies();
		test_store_bounds();
		test_random_traffic();

		$display("Ran %0d bus items under %0d register settings; %0d replies checked.",
			items_sent, settings_used, replies_seen);
		$display("Seen: %0d read bytes, %0d dropped writes, %0d CCC errors, %0d IBI requests.",
			reads_supplied, writes_dropped, ccc_errors, ibi_raised);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// File: files.f
hdl/i3ctb_pkg.sv
hdl/i3ctb_store.sv
hdl/i3c_target_buffer_with_ccc.sv
hdl/i3ctb_checker.sv
tb/sv/i3c_target_buffer_with_ccc_tb.sv
